// ===== rtl/cfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cutter footprint cell classifier package
// Widths, register indexes and the records that travel down the cell chains.
// ----------------------------------------------------------------------------
package cfcc_pkg;

   localparam int W_OFF      = 9;   // signed cell offset
   localparam int W_LEN      = 24;  // lengths in 2^-16 mm
   localparam int W_TOL      = 16;
   localparam int W_D2       = 52;  // squared lateral distance while inside
   localparam int SQRT_STEPS = 26;  // root bits of a W_D2 operand
   localparam int W_SREM     = 28;  // partial remainder of the root cells
   localparam int DIV_STEPS  = W_LEN;

   localparam logic [1:0] CLASS_OUTSIDE = 2'd0;
   localparam logic [1:0] CLASS_CUTTER  = 2'd1;
   localparam logic [1:0] CLASS_RING    = 2'd2;

   typedef enum logic [2:0] {
      CSR_TIP_IS_BALL     = 3'd0,
      CSR_CUTTER_RADIUS   = 3'd1,
      CSR_HEAD_IS_FRUSTUM = 3'd2,
      CSR_HEAD_BOTTOM     = 3'd3,
      CSR_HEAD_TOP        = 3'd4,
      CSR_HEAD_LENGTH     = 3'd5,
      CSR_CELL_SIZE       = 3'd6,
      CSR_TOLERANCE       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]       cls;
      logic             ball;    // ball tip height wanted from the root
      logic             ring;    // linear ring height wanted from the quotient
      logic [W_LEN-1:0] height;
   } meta_type;

   typedef struct packed {
      logic [W_D2-1:0]       op;
      logic [W_SREM-1:0]     rem;
      logic [SQRT_STEPS-1:0] root;
      meta_type              meta;
   } sqrt_stage_type;

   typedef struct packed {
      logic [W_LEN-1:0] rem;
      logic [W_LEN-1:0] low;
      logic [W_LEN-1:0] quot;
      meta_type         meta;
   } div_stage_type;

endpackage

// ===== rtl/cutter_footprint_cell_classifier.sv =====
// ----------------------------------------------------------------------------
// Cutter footprint cell classifier
// Classifies one grid cell against the cutter and head ring and gives its height.
//
//   channel | direction | handshake         | contents
//   req     | in        | tvalid / tready   | tdata: offset_x, offset_y
//   rsp     | out       | tvalid / tready   | tdata: height; tuser: cell_class
//   csr     | in        | valid / ready     | index, wdata of one register
//
// One cell is taken every cycle unless a stalled result holds the pipeline; the
// result passes through a chain of 26 square root cells and 24 divider cells.
// Reset clears all valid flags and loads the register defaults.
// A stalled result holds the whole pipeline; the csr port is always ready.
// ----------------------------------------------------------------------------
module cutter_footprint_cell_classifier
   import cfcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [8:0] offset_x, [17:9] offset_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] height
   output logic [1:0]  rsp_tuser,   // [1:0] cell_class
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // Registers.
   logic             tip_ff, frustum_ff;
   logic [W_LEN-1:0] radius_ff, bottom_ff, top_ff, length_ff, cell_ff;
   logic [W_TOL-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tip_ff     <= 1'b0;
         radius_ff  <= W_LEN'(196608);
         frustum_ff <= 1'b0;
         bottom_ff  <= '0;
         top_ff     <= '0;
         length_ff  <= '0;
         cell_ff    <= W_LEN'(6554);
         tol_ff     <= W_TOL'(7);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIP_IS_BALL:     tip_ff     <= csr_wdata[0];
            CSR_CUTTER_RADIUS:   radius_ff  <= csr_wdata;
            CSR_HEAD_IS_FRUSTUM: frustum_ff <= csr_wdata[0];
            CSR_HEAD_BOTTOM:     bottom_ff  <= csr_wdata;
            CSR_HEAD_TOP:        top_ff     <= csr_wdata;
            CSR_HEAD_LENGTH:     length_ff  <= csr_wdata;
            CSR_CELL_SIZE:       cell_ff    <= csr_wdata;
            CSR_TOLERANCE:       tol_ff     <= csr_wdata[W_TOL-1:0];
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Values derived from the registers, each held in one register behind its multiplier or subtractor.
   logic             widens;
   logic [W_LEN-1:0] head_rad, max_rad;
   logic [W_LEN:0]   lim_cut, lim_head, lim_bot;
   logic [2*W_LEN-1:0] cell2_ff, r2_ff;
   logic [2*W_LEN+1:0] lim_cut_sq_ff, lim_head_sq_ff, lim_bot_sq_ff;
   logic [W_LEN-1:0] den_ff;

   assign widens   = frustum_ff && (top_ff > bottom_ff);
   assign head_rad = widens ? top_ff : bottom_ff;
   assign max_rad  = (radius_ff > head_rad) ? radius_ff : head_rad;
   assign lim_cut  = {1'b0, radius_ff} + (W_LEN+1)'(tol_ff);
   assign lim_head = {1'b0, head_rad} + (W_LEN+1)'(tol_ff);
   assign lim_bot  = {1'b0, bottom_ff} + (W_LEN+1)'(tol_ff);

   always_ff @(posedge clock) begin
      cell2_ff       <= (2*W_LEN)'(cell_ff) * (2*W_LEN)'(cell_ff);
      r2_ff          <= (2*W_LEN)'(radius_ff) * (2*W_LEN)'(radius_ff);
      lim_cut_sq_ff  <= (2*W_LEN+2)'(lim_cut) * (2*W_LEN+2)'(lim_cut);
      lim_head_sq_ff <= (2*W_LEN+2)'(lim_head) * (2*W_LEN+2)'(lim_head);
      lim_bot_sq_ff  <= (2*W_LEN+2)'(lim_bot) * (2*W_LEN+2)'(lim_bot);
      den_ff         <= top_ff - bottom_ff;
   end

   // Pipeline advance: everything moves unless a result is waiting.
   logic rsp_valid_ff;
   logic adv;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage A: offset magnitudes.
   logic [W_OFF-1:0] x_raw, y_raw, ax_in, ay_in, ax_ff, ay_ff;
   logic             a_valid_ff;
   assign x_raw = req_tdata[W_OFF-1:0];
   assign y_raw = req_tdata[2*W_OFF-1:W_OFF];
   assign ax_in = x_raw[W_OFF-1] ? (~x_raw + 1'b1) : x_raw;
   assign ay_in = y_raw[W_OFF-1] ? (~y_raw + 1'b1) : y_raw;

   // Stage B: squared offset and reach products.
   logic [W_OFF-1:0] axm1, aym1;
   logic [17:0]      b_s_ff;
   logic [31:0]      b_pax_ff, b_pay_ff;
   logic             b_far_ff, b_nzx_ff, b_nzy_ff, b_valid_ff;
   assign axm1 = ax_ff - 1'b1;
   assign aym1 = ay_ff - 1'b1;

   // Stage C: inside flag and partial products of the squared distance.
   logic        c_inside_in, c_inside_ff, c_valid_ff;
   logic [41:0] c_pplo_ff, c_pphi_ff;
   assign c_inside_in = !b_far_ff && !((cell_ff != '0) &&
                        ((b_nzx_ff && (b_pax_ff >= 32'(max_rad))) ||
                         (b_nzy_ff && (b_pay_ff >= 32'(max_rad)))));

   // Stage D: squared lateral distance.
   logic [65:0]     d2_wide;
   logic [W_D2-1:0] d_d2_ff;
   logic            d_inside_ff, d_valid_ff;
   assign d2_wide = {c_pphi_ff, 24'b0} + 66'(c_pplo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
      if (adv) begin
         ax_ff       <= ax_in;
         ay_ff       <= ay_in;
         b_s_ff      <= 18'(ax_ff) * 18'(ax_ff) + 18'(ay_ff) * 18'(ay_ff);
         b_pax_ff    <= 32'(axm1[7:0]) * 32'(cell_ff);
         b_pay_ff    <= 32'(aym1[7:0]) * 32'(cell_ff);
         b_far_ff    <= ax_ff[W_OFF-1] | ay_ff[W_OFF-1];
         b_nzx_ff    <= ax_ff != '0;
         b_nzy_ff    <= ay_ff != '0;
         c_inside_ff <= c_inside_in;
         c_pplo_ff   <= 42'(cell2_ff[W_LEN-1:0]) * 42'(b_s_ff);
         c_pphi_ff   <= 42'(cell2_ff[2*W_LEN-1:W_LEN]) * 42'(b_s_ff);
         d_inside_ff <= c_inside_ff;
         d_d2_ff     <= d2_wide[W_D2-1:0];
      end
   end

   // Stage E: classification and root operand.
   logic            in_cut, in_head, in_bot;
   logic [W_D2-1:0] r2_ext, ball_rem;
   sqrt_stage_type  e_stage;
   assign in_cut   = d_inside_ff && (d_d2_ff <= W_D2'(lim_cut_sq_ff));
   assign in_head  = d_inside_ff && (d_d2_ff <= W_D2'(lim_head_sq_ff));
   assign in_bot   = d_d2_ff <= W_D2'(lim_bot_sq_ff);
   assign r2_ext   = W_D2'(r2_ff);
   assign ball_rem = (r2_ext > d_d2_ff) ? (r2_ext - d_d2_ff) : '0;

   always_comb begin
      e_stage             = '0;
      e_stage.op          = d_d2_ff;
      e_stage.meta.cls    = CLASS_OUTSIDE;
      if (in_cut) begin
         e_stage.op        = ball_rem;
         e_stage.meta.cls  = CLASS_CUTTER;
         e_stage.meta.ball = tip_ff;
      end else if (in_head) begin
         e_stage.meta.cls  = CLASS_RING;
         e_stage.meta.ring = widens && !in_bot;
      end
   end

   logic           s_valid [SQRT_STEPS+1];
   sqrt_stage_type s_stage [SQRT_STEPS+1];
   logic           e_valid_ff;
   sqrt_stage_type e_stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
      end
      if (adv) begin
         e_stage_ff <= e_stage;
      end
   end

   assign s_valid[0] = e_valid_ff;
   assign s_stage[0] = e_stage_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      cfcc_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (s_valid[i]),
         .in_stage  (s_stage[i]),
         .out_valid (s_valid[i+1]),
         .out_stage (s_stage[i+1])
      );
   end

   // Stage F: ball height, or ring numerator with its cap test.
   logic [SQRT_STEPS-1:0] root, num_wide;
   meta_type              f_meta_in, f_meta_ff;
   logic [W_LEN-1:0]      f_num_ff;
   logic                  f_valid_ff;
   assign root     = s_stage[SQRT_STEPS].root;
   assign num_wide = (root > SQRT_STEPS'(bottom_ff)) ? (root - SQRT_STEPS'(bottom_ff)) : '0;

   always_comb begin
      f_meta_in = s_stage[SQRT_STEPS].meta;
      if (f_meta_in.ball) begin
         f_meta_in.height = radius_ff - root[W_LEN-1:0];
      end
      if (f_meta_in.ring && (num_wide >= SQRT_STEPS'(den_ff))) begin
         f_meta_in.ring   = 1'b0;
         f_meta_in.height = length_ff;
      end
   end

   // Stage G: dividend of the ring height.
   logic [2*W_LEN-1:0] g_prod_ff;
   meta_type           g_meta_ff;
   logic               g_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= s_valid[SQRT_STEPS];
         g_valid_ff <= f_valid_ff;
      end
      if (adv) begin
         f_meta_ff <= f_meta_in;
         f_num_ff  <= num_wide[W_LEN-1:0];
         g_meta_ff <= f_meta_ff;
         g_prod_ff <= (2*W_LEN)'(length_ff) * (2*W_LEN)'(f_num_ff);
      end
   end

   // The quotient stays below 2^24, so the upper dividend half seeds the remainder.
   logic          q_valid [DIV_STEPS+1];
   div_stage_type q_stage [DIV_STEPS+1];
   assign q_valid[0]      = g_valid_ff;
   assign q_stage[0].rem  = g_prod_ff[2*W_LEN-1:W_LEN];
   assign q_stage[0].low  = g_prod_ff[W_LEN-1:0];
   assign q_stage[0].quot = '0;
   assign q_stage[0].meta = g_meta_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      cfcc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .divisor   (den_ff),
         .in_valid  (q_valid[i]),
         .in_stage  (q_stage[i]),
         .out_valid (q_valid[i+1]),
         .out_stage (q_stage[i+1])
      );
   end

   // Output register.
   logic [W_LEN-1:0] rsp_height_ff;
   logic [1:0]       rsp_class_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q_valid[DIV_STEPS];
      end
      if (adv) begin
         rsp_class_ff  <= q_stage[DIV_STEPS].meta.cls;
         rsp_height_ff <= q_stage[DIV_STEPS].meta.ring ? q_stage[DIV_STEPS].quot
                                                       : q_stage[DIV_STEPS].meta.height;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_height_ff;
   assign rsp_tuser  = rsp_class_ff;

   a_outside_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CLASS_OUTSIDE) |-> rsp_tdata == '0)
      else $error("outside cell with nonzero height");

   a_ring_capped : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CLASS_RING) |-> rsp_tdata <= length_ff)
      else $error("ring height above head length");

   a_ball_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CLASS_CUTTER) |-> rsp_tdata <= radius_ff)
      else $error("cutter height above radius");

endmodule

// ===== rtl/cfcc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step: takes two operand bits and yields one root bit.
// ----------------------------------------------------------------------------
module cfcc_sqrt_cell
   import cfcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  sqrt_stage_type in_stage,
   output logic           out_valid,
   output sqrt_stage_type out_stage
);

   logic           valid_ff;
   sqrt_stage_type stage_ff, stage_in;
   logic [W_SREM-1:0] trial, sub;

   always_comb begin
      trial = {in_stage.rem[W_SREM-3:0], in_stage.op[W_D2-1 -: 2]};
      sub   = {in_stage.root[W_SREM-3:0], 2'b01};
      stage_in      = in_stage;
      stage_in.op   = {in_stage.op[W_D2-3:0], 2'b00};
      if (trial >= sub) begin
         stage_in.rem  = trial - sub;
         stage_in.root = {in_stage.root[SQRT_STEPS-2:0], 1'b1};
      end else begin
         stage_in.rem  = trial;
         stage_in.root = {in_stage.root[SQRT_STEPS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/cfcc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: brings in one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module cfcc_div_cell
   import cfcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [W_LEN-1:0] divisor,
   input  logic             in_valid,
   input  div_stage_type    in_stage,
   output logic             out_valid,
   output div_stage_type    out_stage
);

   logic          valid_ff;
   div_stage_type stage_ff, stage_in;
   logic [W_LEN:0] trial;

   always_comb begin
      trial         = {in_stage.rem, in_stage.low[W_LEN-1]};
      stage_in      = in_stage;
      stage_in.low  = {in_stage.low[W_LEN-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         stage_in.rem  = W_LEN'(trial - {1'b0, divisor});
         stage_in.quot = {in_stage.quot[W_LEN-2:0], 1'b1};
      end else begin
         stage_in.rem  = trial[W_LEN-1:0];
         stage_in.quot = {in_stage.quot[W_LEN-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== tb/cutter_footprint_cell_classifier_test.sv =====
// ----------------------------------------------------------------------------
// Cutter footprint cell classifier testbench
// A short table of cells under the reset registers comes first. Eight phases
// follow, each writing every register first, and cells are sent to the block
// with random idling on both sides, save in the calm last phase. Each result is
// compared with a classifier that is modelled inside this testbench.
// ----------------------------------------------------------------------------
module cutter_footprint_cell_classifier_test;
   import cfcc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REACH_MAX   = 255;
   localparam int DRAIN_WAIT  = 70;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [1:0]       cls;
      logic [W_LEN-1:0] height;
   } cell_result_type;

   typedef struct {
      logic [8:0] ox;
      logic [8:0] oy;
      bit         typed;
      logic [1:0] cls;
      logic [23:0] height;
   } cell_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // Shadow of the register file.
   logic [W_LEN-1:0] reg_file [8];

   cell_result_type cell_expect [$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;

   cutter_footprint_cell_classifier dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
      fail_count++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   // cell^2 * s <= lim^2, tested through a truncating division.
   function automatic bit fits_radius(input longint unsigned cell2, input longint unsigned s,
                                      input longint unsigned lim);
      if (cell2 == 0)
         return 1'b1;
      return s <= (lim * lim) / cell2;
   endfunction

   function automatic longint unsigned offset_size(input logic [8:0] v);
      return v[8] ? 512 - longint'(v) : longint'(v);
   endfunction

   function automatic cell_result_type classify_cell(input logic [8:0] ox,
                                                     input logic [8:0] oy);
      cell_result_type res;
      longint unsigned ax, ay, s, pitch, cell2, r, tol, bottom, top, head, maxrad, reach;
      longint unsigned rem, dq, num, h;
      bit in_reach;
      ax = offset_size(ox);
      ay = offset_size(oy);
      s = ax * ax + ay * ay;
      pitch = reg_file[CSR_CELL_SIZE];
      cell2 = pitch * pitch;
      r = reg_file[CSR_CUTTER_RADIUS];
      tol = reg_file[CSR_TOLERANCE];
      bottom = reg_file[CSR_HEAD_BOTTOM];
      top = reg_file[CSR_HEAD_TOP];
      head = (reg_file[CSR_HEAD_IS_FRUSTUM][0] && top > bottom) ? top : bottom;
      maxrad = r > head ? r : head;
      res.cls = CLASS_OUTSIDE;
      res.height = '0;
      in_reach = (ax <= REACH_MAX) && (ay <= REACH_MAX);
      if (pitch != 0) begin
         reach = (maxrad + pitch - 1) / pitch;
         if (ax > reach || ay > reach)
            in_reach = 1'b0;
      end
      if (in_reach && fits_radius(cell2, s, r + tol)) begin
         res.cls = CLASS_CUTTER;
         if (reg_file[CSR_TIP_IS_BALL][0]) begin
            rem = (r * r > cell2 * s) ? r * r - cell2 * s : 0;
            res.height = W_LEN'(r - int_sqrt(rem));
         end
      end else if (in_reach && fits_radius(cell2, s, head + tol)) begin
         res.cls = CLASS_RING;
         if (reg_file[CSR_HEAD_IS_FRUSTUM][0] && top > bottom &&
             !fits_radius(cell2, s, bottom + tol)) begin
            dq = int_sqrt(cell2 * s);
            num = dq > bottom ? dq - bottom : 0;
            h = (longint'(reg_file[CSR_HEAD_LENGTH]) * num) / (top - bottom);
            res.height = W_LEN'(h < reg_file[CSR_HEAD_LENGTH] ? h : reg_file[CSR_HEAD_LENGTH]);
         end
      end
      return res;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      reg_file[idx] = (idx == CSR_TIP_IS_BALL || idx == CSR_HEAD_IS_FRUSTUM) ?
                      value & 24'h1 :
                      (idx == CSR_TOLERANCE) ? value & 24'hFFFF : value;
   endtask

   task automatic wait_drained();
      while (cell_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic send_cell(input cell_row_type row);
      cell_result_type want;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, row.oy, row.ox};
      do @(posedge clock); while (!req_tready);
      if (row.typed) begin
         want.cls = row.cls;
         want.height = row.height;
      end else begin
         want = classify_cell(row.ox, row.oy);
      end
      cell_expect.push_back(want);
   endtask

   // Offsets mostly around the tool reach, now and then any 9-bit pattern.
   function automatic logic [8:0] pick_offset();
      longint unsigned pitch, r, bottom, top, maxrad, reach;
      int lim, v;
      pitch = reg_file[CSR_CELL_SIZE];
      r = reg_file[CSR_CUTTER_RADIUS];
      bottom = reg_file[CSR_HEAD_BOTTOM];
      top = reg_file[CSR_HEAD_TOP];
      maxrad = r > bottom ? r : bottom;
      maxrad = maxrad > top ? maxrad : top;
      reach = (maxrad + pitch - 1) / pitch;
      lim = reach + 2 > REACH_MAX ? REACH_MAX : int'(reach) + 2;
      if ($urandom_range(0, 9) == 0)
         return 9'($urandom);
      v = $urandom_range(0, 2 * lim);
      return 9'(v - lim);
   endfunction

   task automatic load_setting(input int phase);
      logic [23:0] r, pitch, bottom, top;
      case (phase)
         1: begin
            write_reg(CSR_TIP_IS_BALL, 24'd1);
            write_reg(CSR_CUTTER_RADIUS, 24'hFFFFFF);
            write_reg(CSR_HEAD_IS_FRUSTUM, 24'd1);
            write_reg(CSR_HEAD_BOTTOM, 24'd0);
            write_reg(CSR_HEAD_TOP, 24'hFFFFFF);
            write_reg(CSR_HEAD_LENGTH, 24'hFFFFFF);
            write_reg(CSR_CELL_SIZE, 24'hFFFFFF);
            write_reg(CSR_TOLERANCE, 24'hFFFF);
         end
         2: begin
            write_reg(CSR_TIP_IS_BALL, 24'd1);
            write_reg(CSR_CUTTER_RADIUS, 24'd1);
            write_reg(CSR_HEAD_IS_FRUSTUM, 24'd1);
            write_reg(CSR_HEAD_BOTTOM, 24'd0);
            write_reg(CSR_HEAD_TOP, 24'd3);
            write_reg(CSR_HEAD_LENGTH, 24'd0);
            write_reg(CSR_CELL_SIZE, 24'd1);
            write_reg(CSR_TOLERANCE, 24'd0);
         end
         3: begin
            // Very large radii against a fine pitch: most cells lie well inside the reach.
            write_reg(CSR_CUTTER_RADIUS, 24'hFFFFFF);
            write_reg(CSR_HEAD_BOTTOM, 24'hFFFFFF);
            write_reg(CSR_HEAD_TOP, 24'hFFFFFF);
            write_reg(CSR_CELL_SIZE, 24'd1);
            write_reg(CSR_TIP_IS_BALL, 24'd0);
            write_reg(CSR_HEAD_IS_FRUSTUM, 24'd0);
            write_reg(CSR_HEAD_LENGTH, 24'hFFFFFF);
            write_reg(CSR_TOLERANCE, 24'd0);
         end
         default: begin
            r = 24'($urandom_range(1, 24'hFFFFFF >> $urandom_range(0, 12)));
            pitch = 24'(r / $urandom_range(1, 120));
            if (pitch == 0)
               pitch = 24'd1;
            bottom = 24'(r + $urandom_range(0, r) - r / 2);
            top = ($urandom_range(0, 3) == 0) ? 24'(bottom - bottom / 4)
                                              : 24'(bottom + $urandom_range(0, r));
            write_reg(CSR_TIP_IS_BALL, 24'($urandom_range(0, 1)));
            write_reg(CSR_CUTTER_RADIUS, r);
            write_reg(CSR_HEAD_IS_FRUSTUM, 24'($urandom_range(0, 3) != 0));
            write_reg(CSR_HEAD_BOTTOM, bottom);
            write_reg(CSR_HEAD_TOP, top);
            write_reg(CSR_HEAD_LENGTH, 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(CSR_CELL_SIZE, pitch);
            write_reg(CSR_TOLERANCE, 24'($urandom_range(0, 3) == 0 ?
                                         $urandom_range(0, 16'hFFFF) :
                                         $urandom_range(0, 64)));
         end
      endcase
      csr_valid <= 1'b0;
   endtask

   // Receiver side: random stalls, or one long hold while the sender keeps going.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_tready <= 1'b1;
            hold_req = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cell_expect.size() == 0) begin
            report_mismatch("unexpected transfer, height", rsp_tdata, 0);
         end else begin
            want = cell_expect.pop_front();
            if (rsp_tuser !== want.cls)
               report_mismatch("cell_class", rsp_tuser, want.cls);
            if (rsp_tdata !== want.height)
               report_mismatch("height", rsp_tdata, want.height);
         end
      end
   end

   initial begin
      cell_row_type table_rows [$];
      cell_row_type row;
      reg_file[CSR_TIP_IS_BALL] = 0;
      reg_file[CSR_CUTTER_RADIUS] = 196608;
      reg_file[CSR_HEAD_IS_FRUSTUM] = 0;
      reg_file[CSR_HEAD_BOTTOM] = 0;
      reg_file[CSR_HEAD_TOP] = 0;
      reg_file[CSR_HEAD_LENGTH] = 0;
      reg_file[CSR_CELL_SIZE] = 6554;
      reg_file[CSR_TOLERANCE] = 7;
      // Reset registers: 3 mm flat cutter, 0.1 mm pitch, reach of 30 cells.
      table_rows = '{
         '{9'd0, 9'd0, 1, CLASS_CUTTER, 24'd0},
         '{9'd255, 9'd255, 1, CLASS_OUTSIDE, 24'd0},
         '{9'h101, 9'h101, 1, CLASS_OUTSIDE, 24'd0},
         '{9'h100, 9'd0, 1, CLASS_OUTSIDE, 24'd0},
         '{9'd0, 9'h100, 1, CLASS_OUTSIDE, 24'd0},
         '{9'd31, 9'd0, 1, CLASS_OUTSIDE, 24'd0},
         '{9'd30, 9'd0, 0, 0, 0},
         '{-9'sd30, 9'd0, 0, 0, 0},
         '{9'd0, -9'sd29, 0, 0, 0},
         '{9'd21, 9'd21, 0, 0, 0},
         '{9'd22, 9'd21, 0, 0, 0},
         '{-9'sd1, -9'sd1, 0, 0, 0},
         '{9'd29, 9'd8, 0, 0, 0},
         '{9'h0AA, 9'h155, 0, 0, 0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (table_rows[i])
         send_cell(table_rows[i]);
      for (int phase = 1; phase <= 8; phase++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         load_setting(phase);
         calm = (phase == 8);
         for (int n = 0; n < 235; n++) begin
            if (phase == 4 && n == 40)
               hold_req = 1'b1;
            if (phase == 5 && n == 100) begin
               req_tvalid <= 1'b0;
               while (cell_expect.size() != 0)
                  @(posedge clock);
            end
            row.ox = pick_offset();
            row.oy = pick_offset();
            row.typed = 1'b0;
            send_cell(row);
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();
      if (fail_count == 0 && cell_expect.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
